[hw/rtl/rhcs_pkg.sv]
// Shared types, signature bytes and header constants for the header chain scanner.
`timescale 1ns / 1ps

package rhcs_pkg;

    localparam logic [7:0] SIG_B0        = 8'h52;
    localparam logic [7:0] SIG_B1        = 8'h61;
    localparam logic [7:0] SIG_B2        = 8'h72;
    localparam logic [7:0] SIG_B3        = 8'h21;
    localparam logic [7:0] SIG_B4        = 8'h1A;
    localparam logic [7:0] SIG_B5        = 8'h07;
    localparam logic [7:0] SIG_OLD_TAIL  = 8'h00;
    localparam logic [7:0] SIG_NEW_VER   = 8'h01;
    localparam logic [7:0] SIG_NEW_TAIL  = 8'h00;
    localparam logic [7:0] END_BLOCK     = 8'h7B;

    localparam int unsigned HDR_LEN      = 7;
    localparam int unsigned SIG_OLD_LEN  = 7;
    localparam int unsigned SIG_NEW_LEN  = 8;

    localparam logic [2:0] HDR_IDX_TYPE  = 3'd2;
    localparam logic [2:0] HDR_IDX_SIZEL = 3'd5;
    localparam logic [2:0] HDR_IDX_SIZEH = 3'd6;
    localparam logic [2:0] SIG_IDX_LAST  = 3'd6;

    typedef enum logic [3:0] {
        PH_SIG  = 4'b0001,
        PH_HDR  = 4'b0010,
        PH_SKIP = 4'b0100,
        PH_STOP = 4'b1000
    } rhcs_phase_t;

    typedef struct packed {
        logic        signature_match;
        logic        newer_format;
        logic        archive_valid;
        logic        truncated;
        logic [15:0] block_total;
        logic [31:0] span_length;
    } rhcs_result_t;

    function automatic logic [7:0] sig_old_byte(input logic [2:0] idx);
        logic [7:0] b;
        case (idx)
            3'd0:    b = SIG_B0;
            3'd1:    b = SIG_B1;
            3'd2:    b = SIG_B2;
            3'd3:    b = SIG_B3;
            3'd4:    b = SIG_B4;
            3'd5:    b = SIG_B5;
            default: b = SIG_OLD_TAIL;
        endcase
        return b;
    endfunction

    function automatic logic [7:0] sig_new_byte(input logic [2:0] idx);
        logic [7:0] b;
        case (idx)
            3'd0:    b = SIG_B0;
            3'd1:    b = SIG_B1;
            3'd2:    b = SIG_B2;
            3'd3:    b = SIG_B3;
            3'd4:    b = SIG_B4;
            3'd5:    b = SIG_B5;
            3'd6:    b = SIG_NEW_VER;
            default: b = SIG_NEW_TAIL;
        endcase
        return b;
    endfunction

endpackage

[hw/rtl/rhcs_walker.sv]
// Per-byte signature check and block header walk with the scan state registers.
`timescale 1ns / 1ps

module rhcs_walker #(
    parameter int LENGTH_BITS = 32,
    parameter int COUNT_BITS  = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  accept,
    input  logic [7:0]            data_byte,
    input  logic                  last_byte,
    output rhcs_pkg::rhcs_result_t result
);
    import rhcs_pkg::*;

    localparam logic [LENGTH_BITS-1:0] POS_LIMIT = {{(LENGTH_BITS-1){1'b1}}, 1'b0};
    localparam logic [COUNT_BITS-1:0]  CNT_MAX   = {COUNT_BITS{1'b1}};

    rhcs_phase_t             phase_reg, phase_next;
    logic [LENGTH_BITS-1:0]  pos_reg, pos_next;
    logic [2:0]              hidx_reg, hidx_next;
    logic [7:0]              size_low_reg, size_low_next;
    logic [7:0]              type_reg, type_next;
    logic [15:0]             skip_reg, skip_next;
    logic [LENGTH_BITS-1:0]  end_reg, end_next;
    logic [COUNT_BITS-1:0]   count_reg, count_next;
    logic                    old_ok_reg, old_ok_next;
    logic                    new_ok_reg, new_ok_next;
    logic                    newer_reg, newer_next;

    logic [LENGTH_BITS-1:0]  pos_plus;
    logic [15:0]             hdr_size;
    logic                    do_header;
    logic                    do_accept;
    logic                    sig_short;

    assign pos_plus  = pos_reg + LENGTH_BITS'(1);
    assign hdr_size  = {data_byte, size_low_reg};
    assign sig_short = (pos_reg < LENGTH_BITS'(7));

    always_comb
    begin
        phase_next    = phase_reg;
        hidx_next     = hidx_reg;
        size_low_next = size_low_reg;
        type_next     = type_reg;
        skip_next     = skip_reg;
        end_next      = end_reg;
        count_next    = count_reg;
        old_ok_next   = old_ok_reg;
        new_ok_next   = new_ok_reg;
        newer_next    = newer_reg;
        do_header     = 1'b0;
        do_accept     = 1'b0;

        case (phase_reg)
            PH_SIG:
            begin
                if (sig_short)
                begin
                    if (data_byte != sig_old_byte(pos_reg[2:0]))
                        old_ok_next = 1'b0;
                    if (data_byte != sig_new_byte(pos_reg[2:0]))
                        new_ok_next = 1'b0;
                    if (pos_reg[2:0] == SIG_IDX_LAST)
                    begin
                        end_next = LENGTH_BITS'(SIG_OLD_LEN);
                        if (!new_ok_next)
                        begin
                            phase_next = PH_HDR;
                            hidx_next  = '0;
                        end
                    end
                end
                else if (data_byte == SIG_NEW_TAIL)
                begin
                    newer_next = 1'b1;
                    end_next   = LENGTH_BITS'(SIG_NEW_LEN);
                    phase_next = PH_HDR;
                    hidx_next  = '0;
                end
                else
                begin
                    // byte counts as header byte zero
                    new_ok_next = 1'b0;
                    phase_next  = PH_HDR;
                    hidx_next   = 3'd1;
                end
            end
            PH_HDR:
            begin
                do_header = 1'b1;
            end
            PH_SKIP:
            begin
                skip_next = skip_reg - 16'd1;
                if (skip_next == 16'd0)
                    do_accept = 1'b1;
            end
            PH_STOP:
            begin
            end
            default:
            begin
                phase_next = PH_STOP;
            end
        endcase

        if (do_header)
        begin
            if (hidx_reg == HDR_IDX_TYPE)
                type_next = data_byte;
            if (hidx_reg == HDR_IDX_SIZEL)
                size_low_next = data_byte;
            if (hidx_reg != HDR_IDX_SIZEH)
                hidx_next = hidx_reg + 3'd1;
            else
            begin
                hidx_next = '0;
                if (hdr_size < 16'(HDR_LEN))
                    phase_next = PH_STOP;
                else if (hdr_size == 16'(HDR_LEN))
                    do_accept = 1'b1;
                else
                begin
                    skip_next  = hdr_size - 16'(HDR_LEN);
                    phase_next = PH_SKIP;
                end
            end
        end

        if (do_accept)
        begin
            if (count_reg != CNT_MAX)
                count_next = count_reg + COUNT_BITS'(1);
            end_next = pos_plus;
            if (!newer_reg && type_next == END_BLOCK)
                phase_next = PH_STOP;
            else
                phase_next = PH_HDR;
        end

        pos_next = (pos_reg != POS_LIMIT) ? pos_plus : pos_reg;
    end

    always_comb
    begin
        if (pos_reg < LENGTH_BITS'(6))
        begin
            result.signature_match = 1'b0;
            result.newer_format    = 1'b0;
            result.archive_valid   = 1'b0;
            result.truncated       = 1'b1;
            result.block_total     = '0;
            result.span_length     = 32'(pos_plus);
        end
        else
        begin
            result.signature_match = old_ok_next || newer_next;
            result.newer_format    = newer_next;
            result.archive_valid   = (count_next != '0);
            result.truncated       = 1'b0;
            result.block_total     = 16'(count_next);
            result.span_length     = 32'(end_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_SIG;
            pos_reg      <= '0;
            hidx_reg     <= '0;
            size_low_reg <= '0;
            type_reg     <= '0;
            skip_reg     <= '0;
            end_reg      <= '0;
            count_reg    <= '0;
            old_ok_reg   <= 1'b1;
            new_ok_reg   <= 1'b1;
            newer_reg    <= 1'b0;
        end
        else if (accept)
        begin
            if (last_byte)
            begin
                // restart for the next blob
                phase_reg    <= PH_SIG;
                pos_reg      <= '0;
                hidx_reg     <= '0;
                size_low_reg <= '0;
                type_reg     <= '0;
                skip_reg     <= '0;
                end_reg      <= '0;
                count_reg    <= '0;
                old_ok_reg   <= 1'b1;
                new_ok_reg   <= 1'b1;
                newer_reg    <= 1'b0;
            end
            else
            begin
                phase_reg    <= phase_next;
                pos_reg      <= pos_next;
                hidx_reg     <= hidx_next;
                size_low_reg <= size_low_next;
                type_reg     <= type_next;
                skip_reg     <= skip_next;
                end_reg      <= end_next;
                count_reg    <= count_next;
                old_ok_reg   <= old_ok_next;
                new_ok_reg   <= new_ok_next;
                newer_reg    <= newer_next;
            end
        end
    end

`ifndef ASSERT_OFF
    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        accept && last_byte |=> pos_reg == '0 && phase_reg == PH_SIG)
        else $error("scan state not restarted after final byte");

    a_hidx_idle: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg != PH_HDR |-> hidx_reg == '0)
        else $error("header index nonzero outside header phase");

    a_newer_sig: assert property (@(posedge clk) disable iff (!rst_n)
        newer_reg |-> new_ok_reg)
        else $error("newer format flagged without matching signature");

    a_skip_live: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_SKIP |-> skip_reg != '0)
        else $error("skip phase with zero bytes left");
`endif

endmodule

[hw/rtl/rhcs_out_stage.sv]
// Result register with valid/ready handshake toward the consumer.
`timescale 1ns / 1ps

module rhcs_out_stage (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   load,
    input  rhcs_pkg::rhcs_result_t result_in,
    output logic                   can_load,
    output logic                   result_valid,
    input  logic                   result_ready,
    output rhcs_pkg::rhcs_result_t result_q
);
    import rhcs_pkg::*;

    logic         valid_reg;
    rhcs_result_t data_reg;

    assign can_load     = !valid_reg || result_ready;
    assign result_valid = valid_reg;
    assign result_q     = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (load)
            valid_reg <= 1'b1;
        else if (result_ready)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= result_in;
    end

`ifndef ASSERT_OFF
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        !(load && valid_reg && !result_ready))
        else $error("pending result overwritten");
`endif

endmodule

[hw/rtl/rar_header_chain_scanner.sv]
// Top level of the archive signature and block header chain scanner.
`timescale 1ns / 1ps

// Takes one blob byte per transaction, starting at a candidate offset, and at the byte
// marked last_byte delivers one summary transaction: signature match, newer format,
// validity, truncation, block count and span length. The scan state updates in a single
// pass between the state registers and the result register, so a byte can be accepted
// every cycle. Only a final byte waits, and only while an earlier result is still held
// in the result register.
module rar_header_chain_scanner #(
    parameter int LENGTH_BITS = 32,
    parameter int COUNT_BITS  = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_ready,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    output logic        result_valid,
    input  logic        result_ready,
    output logic        signature_match,
    output logic        newer_format,
    output logic        archive_valid,
    output logic        truncated,
    output logic [15:0] block_total,
    output logic [31:0] span_length
);
    import rhcs_pkg::*;

    logic         accept;
    logic         can_load;
    rhcs_result_t result_next;
    rhcs_result_t result_q;

    assign item_ready = can_load || !last_byte;
    assign accept     = item_valid && item_ready;

    rhcs_walker #(
        .LENGTH_BITS (LENGTH_BITS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_walker (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .data_byte (data_byte),
        .last_byte (last_byte),
        .result    (result_next)
    );

    rhcs_out_stage u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (accept && last_byte),
        .result_in    (result_next),
        .can_load     (can_load),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_q     (result_q)
    );

    assign signature_match = result_q.signature_match;
    assign newer_format    = result_q.newer_format;
    assign archive_valid   = result_q.archive_valid;
    assign truncated       = result_q.truncated;
    assign block_total     = result_q.block_total;
    assign span_length     = result_q.span_length;

endmodule
